FILE: rtl/core/mbsfr_pkg.sv
// Shared types and constants of the slave frame receiver.
// No dependencies; imported by the receiver and its checker.
package mbsfr_pkg;

   localparam int unsigned OP_W         = 2;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned FRAME_LEN_W  = 9;
   localparam int unsigned CMD_LEN_W    = 9;
   localparam int unsigned STATUS_W     = 3;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 9;

   // Request operations.
   localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDRESS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_LENGTH = 2'd1;

   // Frame layout constants.
   localparam logic [BYTE_W-1:0] FC_WRITE_MULTIPLE = 8'h10;
   localparam int unsigned       FC_POS            = 1;
   localparam int unsigned       BYTE_COUNT_POS    = 6;
   localparam int unsigned       MULTI_OVERHEAD    = 9;

   typedef enum logic [STATUS_W-1:0] {
      ST_IGNORED  = 3'd0,
      ST_STORED   = 3'd1,
      ST_COMPLETE = 3'd2,
      ST_DROPPED  = 3'd3,
      ST_RELEASED = 3'd4,
      ST_READ     = 3'd5
   } status_type;

   typedef struct packed {
      status_type             status;
      logic                   frame_ready;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic                   read_hit;
   } stage_type;

endpackage

FILE: rtl/core/modbus_slave_frame_receiver.sv
// Slave frame receiver top level: framing control, buffer and result path.
// Depends on mbsfr_pkg and mbsfr_ram.
//
// Usage:
//   req_* carries one transaction per item: a received serial byte, a release
//   of the held frame, or a read of one frame buffer byte. rsp_* returns one
//   result transaction per request: status, frame_ready, frame_length and
//   read_data (zero unless a read hits the buffer).
//   csr_* writes slave_address (index 0) and command_length (index 1); it is
//   always ready and is meant to be used only while no request is in flight.
//   The framing update, the stage register and the buffer read data all load
//   at the accepting edge, and the output register then presents the result
//   on rsp_valid. Throughput is one transaction per cycle while rsp_ready is
//   held high. When the receiver stalls rsp_ready, the output register holds
//   its result, the stage register holds the next one, and req_ready drops
//   only once both are full.
//   Reset clears the framing state (hunting, count zero, no frame held) and
//   sets slave_address to 1 and command_length to 8. Buffer contents are not
//   cleared; only bytes written since reset may be read back.
module modbus_slave_frame_receiver
   import mbsfr_pkg::*;
#(
   parameter int unsigned BUFFER_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   input  logic [BYTE_W-1:0]      req_read_index,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_frame_ready,
   output logic [FRAME_LEN_W-1:0] rsp_frame_length,
   output logic [BYTE_W-1:0]      rsp_read_data,
   // configuration channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned AW   = $clog2(BUFFER_DEPTH);
   localparam int unsigned CW   = $clog2(BUFFER_DEPTH + 1);
   localparam int unsigned CMPW = (CW > CMD_LEN_W) ? CW : CMD_LEN_W;

   // Configuration registers.
   logic [BYTE_W-1:0]    slave_address_ff,  slave_address_in;
   logic [CMD_LEN_W-1:0] command_length_ff, command_length_in;

   // Framing state.
   logic              in_frame_ff,   in_frame_in;
   logic [CW-1:0]     byte_count_ff, byte_count_in;
   logic              ready_lock_ff, ready_lock_in;
   // Shadow copies of buffer bytes the completion check needs.
   logic [BYTE_W-1:0] func_code_ff,  func_code_in;
   logic [BYTE_W-1:0] multi_count_ff, multi_count_in;

   // Stage and output registers.
   logic              stage_valid_ff, stage_valid_in;
   stage_type         stage_ff,       stage_in;
   logic              out_valid_ff,   out_valid_in;
   stage_type         out_ff,         out_in;
   logic [BYTE_W-1:0] out_data_ff,    out_data_in;

   // Buffer access.
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic              rd_en;
   logic [BYTE_W-1:0] rd_data;

   logic              req_fire;
   logic              stage_move;
   logic [CW-1:0]     count_inc;
   logic [BYTE_W-1:0] func_code_cur;
   logic [BYTE_W-1:0] multi_count_cur;
   logic              frame_done;
   logic              read_in_range;
   status_type        status_cur;

   // Advance the stage into the output register when the output is free.
   assign stage_move = stage_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !stage_valid_ff || stage_move;
   assign req_fire   = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // Completion check; bypass the byte being written at the shadowed places.
   assign count_inc       = byte_count_ff + CW'(1);
   assign func_code_cur   = (byte_count_ff == CW'(FC_POS)) ? req_rx_byte : func_code_ff;
   assign multi_count_cur = (byte_count_ff == CW'(BYTE_COUNT_POS)) ?
                            req_rx_byte : multi_count_ff;

   always_comb begin
      if (func_code_cur != FC_WRITE_MULTIPLE) begin
         frame_done = CMPW'(count_inc) >= CMPW'(command_length_ff);
      end else begin
         frame_done = CMPW'(count_inc) ==
                      CMPW'(multi_count_cur) + CMPW'(MULTI_OVERHEAD);
      end
   end

   assign read_in_range = CMPW'(req_read_index) < CMPW'(BUFFER_DEPTH);
   assign rd_en         = req_fire && (req_operation == OP_READ) && read_in_range;

   // Framing update for the transaction at the request port.
   always_comb begin
      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      ready_lock_in  = ready_lock_ff;
      func_code_in   = func_code_ff;
      multi_count_in = multi_count_ff;
      wr_en          = 1'b0;
      wr_addr        = AW'(byte_count_ff);
      status_cur     = ST_IGNORED;
      unique case (req_operation)
         OP_RX_BYTE: begin
            priority if (ready_lock_ff) begin
               status_cur = ST_IGNORED;
            end else if (!in_frame_ff) begin
               if (req_rx_byte == slave_address_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = '0;
                  byte_count_in = CW'(1);
                  in_frame_in   = 1'b1;
                  status_cur    = ST_STORED;
               end
            end else if (CMPW'(byte_count_ff) >= CMPW'(BUFFER_DEPTH)) begin
               // Drop on full buffer and stay in the frame.
               status_cur = ST_DROPPED;
            end else begin
               wr_en          = 1'b1;
               byte_count_in  = count_inc;
               func_code_in   = func_code_cur;
               multi_count_in = multi_count_cur;
               if (frame_done) begin
                  ready_lock_in = 1'b1;
                  in_frame_in   = 1'b0;
                  status_cur    = ST_COMPLETE;
               end else begin
                  status_cur = ST_STORED;
               end
            end
         end
         OP_RELEASE: begin
            ready_lock_in = 1'b0;
            status_cur    = ST_RELEASED;
         end
         OP_READ: begin
            status_cur = ST_READ;
         end
         default: begin
            status_cur = ST_IGNORED;
         end
      endcase
   end

   // Configuration writes; unknown indexes change nothing.
   always_comb begin
      slave_address_in  = slave_address_ff;
      command_length_in = command_length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS:  slave_address_in  = csr_wdata[BYTE_W-1:0];
            CSR_COMMAND_LENGTH: command_length_in = csr_wdata[CMD_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage and output register loading.
   always_comb begin
      stage_valid_in        = stage_valid_ff;
      stage_in              = stage_ff;
      out_valid_in          = out_valid_ff;
      out_in                = out_ff;
      out_data_in           = out_data_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (stage_move) begin
         out_valid_in   = 1'b1;
         out_in         = stage_ff;
         out_data_in    = stage_ff.read_hit ? rd_data : '0;
         stage_valid_in = 1'b0;
      end
      if (req_fire) begin
         stage_valid_in        = 1'b1;
         stage_in.status       = status_cur;
         stage_in.frame_ready  = ready_lock_in;
         stage_in.frame_length = FRAME_LEN_W'(byte_count_in);
         stage_in.read_hit     = rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff  <= BYTE_W'(1);
         command_length_ff <= CMD_LEN_W'(8);
         in_frame_ff       <= 1'b0;
         byte_count_ff     <= '0;
         ready_lock_ff     <= 1'b0;
         func_code_ff      <= '0;
         multi_count_ff    <= '0;
         stage_valid_ff    <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         slave_address_ff  <= slave_address_in;
         command_length_ff <= command_length_in;
         stage_valid_ff    <= stage_valid_in;
         out_valid_ff      <= out_valid_in;
         if (req_fire) begin
            in_frame_ff    <= in_frame_in;
            byte_count_ff  <= byte_count_in;
            ready_lock_ff  <= ready_lock_in;
            func_code_ff   <= func_code_in;
            multi_count_ff <= multi_count_in;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      out_ff      <= out_in;
      out_data_ff <= out_data_in;
   end

   mbsfr_ram #(
      .DATA_W (BYTE_W),
      .DEPTH  (BUFFER_DEPTH)
   ) u_frame_buffer (
      .clock   (clock),
      .wr_en   (req_fire && wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (AW'(req_read_index)),
      .rd_data (rd_data)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_frame_ready  = out_ff.frame_ready;
   assign rsp_frame_length = out_ff.frame_length;
   assign rsp_read_data    = out_data_ff;

endmodule

FILE: rtl/core/mbsfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the frame buffer of the receiver.
module mbsfr_ram #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/mbsfr_checker.sv
// Port-level checks of the slave frame receiver, bound to its top level.
// Depends on mbsfr_pkg and modbus_slave_frame_receiver.
module mbsfr_checker
   import mbsfr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_W-1:0]    rsp_status,
   input logic                   rsp_frame_ready,
   input logic [FRAME_LEN_W-1:0] rsp_frame_length,
   input logic [BYTE_W-1:0]      rsp_read_data
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_frame_length) && $stable(rsp_read_data))
      else $error("stalled result changed");

   // A completed frame reports the lock set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_COMPLETE) |-> rsp_frame_ready)
      else $error("frame complete without frame_ready");

   // Release, store and drop only happen with the lock clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_RELEASED || rsp_status == ST_STORED ||
      rsp_status == ST_DROPPED) |-> !rsp_frame_ready)
      else $error("frame_ready set on unlocked status");

   // Only a read returns data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_data != '0) |-> rsp_status == ST_READ)
      else $error("read_data nonzero outside a read");

   // A stored byte implies a nonempty buffer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_STORED) |-> rsp_frame_length != '0)
      else $error("stored byte with empty frame");

endmodule

bind modbus_slave_frame_receiver mbsfr_checker u_mbsfr_checker (.*);
